FILE: src/udpdf_pkg.sv
package udpdf_pkg;

  typedef enum logic [3:0] {
    PH_CMD    = 4'd0,
    PH_H_ATYP = 4'd1,
    PH_H_DLEN = 4'd2,
    PH_H_ADDR = 4'd3,
    PH_H_PORT = 4'd4,
    PH_H_CRLF = 4'd5,
    PH_TCP    = 4'd6,
    PH_U_ATYP = 4'd7,
    PH_U_DLEN = 4'd8,
    PH_U_ADDR = 4'd9,
    PH_U_PORT = 4'd10,
    PH_U_LEN  = 4'd11,
    PH_U_CRLF = 4'd12,
    PH_U_PAY  = 4'd13
  } phase_e;

  localparam logic [2:0] KIND_CMD     = 3'd0;
  localparam logic [2:0] KIND_ATYP    = 3'd1;
  localparam logic [2:0] KIND_DLEN    = 3'd2;
  localparam logic [2:0] KIND_ADDR    = 3'd3;
  localparam logic [2:0] KIND_PORT    = 3'd4;
  localparam logic [2:0] KIND_LEN     = 3'd5;
  localparam logic [2:0] KIND_CRLF    = 3'd6;
  localparam logic [2:0] KIND_PAYLOAD = 3'd7;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CMD     = 2'd1;
  localparam logic [1:0] ERR_ATYP    = 2'd2;
  localparam logic [1:0] ERR_LENGTH  = 2'd3;

  localparam logic [1:0] ADDR_IPV4   = 2'd0;
  localparam logic [1:0] ADDR_DOMAIN = 2'd1;
  localparam logic [1:0] ADDR_IPV6   = 2'd2;

  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] CMD_UDP_ASSOC = 8'h03;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;

  localparam logic [7:0] IPV4_BYTES = 8'd4;
  localparam logic [7:0] IPV6_BYTES = 8'd16;
  localparam logic [7:0] IDX_SAT    = 8'hFF;

  localparam logic [15:0] MAX_UDP_PAYLOAD_RST = 16'd8192;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [2:0]  byte_kind;
    logic        is_udp;
    logic [1:0]  address_kind;
    logic [7:0]  field_index;
    logic        frame_last;
    logic [15:0] frame_length;
    logic        error;
    logic [1:0]  error_code;
  } result_t;

endpackage

FILE: src/proxy_request_udp_deframer_top.sv
// Request-header and UDP-frame deframer for one proxy connection.
// Input channel: in_valid_i / in_stall_o carry one client byte per request
// (data_byte_i, new_connection_i). Set new_connection_i on the first byte of
// a connection to clear the parse state and any sticky error.
// Output channel: out_valid_o / out_stall_i carry one tagged byte per input
// byte: field kind, field index, protocol, address type, frame end, declared
// UDP length and error status.
// out_valid_o rises in the cycle after a byte is accepted. One byte is taken per
// cycle while the receiver does not stall; the parse state advances in a single
// pass ahead of the result register, with no separate work step per byte.
// When the receiver stalls, the result register holds its byte and
// in_stall_o rises, so input is held off until the result is taken; a new
// byte is accepted in the same cycle the held one leaves.
// cfg_we_i / cfg_wdata_i write max_udp_payload; write only while idle.
// Reset clears the parse state, empties the result register and sets
// max_udp_payload to 8192. A declared frame length above it gives error 3.
module proxy_request_udp_deframer_top import udpdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_connection_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_out_o,
  output logic [2:0]  byte_kind_o,
  output logic        is_udp_o,
  output logic [1:0]  address_kind_o,
  output logic [7:0]  field_index_o,
  output logic        frame_last_o,
  output logic [15:0] frame_length_o,
  output logic        error_o,
  output logic [1:0]  error_code_o
);

  logic [15:0] max_udp_payload_q;
  logic        accept;
  result_t     result_d;
  result_t     result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_udp_payload_q <= MAX_UDP_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      max_udp_payload_q <= cfg_wdata_i;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  udpdf_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .new_connection_i  (new_connection_i),
    .max_udp_payload_i (max_udp_payload_q),
    .result_o          (result_d)
  );

  udpdf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .result_i    (result_d),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_q)
  );

  assign data_out_o     = result_q.data_out;
  assign byte_kind_o    = result_q.byte_kind;
  assign is_udp_o       = result_q.is_udp;
  assign address_kind_o = result_q.address_kind;
  assign field_index_o  = result_q.field_index;
  assign frame_last_o   = result_q.frame_last;
  assign frame_length_o = result_q.frame_length;
  assign error_o        = result_q.error;
  assign error_code_o   = result_q.error_code;

  a_accept_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o
  ) else $error("accepted byte produced no result");

  a_error_code_match: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_o == (error_code_o != ERR_NONE)
  ) else $error("error flag disagrees with error code");

  a_frame_last_kind: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> byte_kind_o == KIND_CRLF ||
                                    byte_kind_o == KIND_PAYLOAD
  ) else $error("frame end on a header field byte");

endmodule

FILE: src/udpdf_parser.sv
module udpdf_parser import udpdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        new_connection_i,
  input  logic [15:0] max_udp_payload_i,
  output result_t     result_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  fcnt_q, fcnt_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [15:0] lacc_q, lacc_d;
  logic [15:0] prem_q, prem_d;
  logic        udp_q, udp_d;
  logic [1:0]  akind_q, akind_d;
  logic [1:0]  err_q, err_d;

  phase_e      phase_c;
  logic        frame;
  logic [7:0]  abytes;
  logic [7:0]  fcnt_inc;
  logic [15:0] lacc_full;
  logic [15:0] prem_dec;
  logic [2:0]  kind;
  logic [7:0]  idx;
  logic        last;
  logic [15:0] flen;

  always_comb begin
    // clear the parse state ahead of the first byte of a new connection
    if (new_connection_i) begin
      phase_c = PH_CMD;
      fcnt_d  = '0;
      dlen_d  = '0;
      lacc_d  = '0;
      prem_d  = '0;
      udp_d   = 1'b0;
      akind_d = ADDR_IPV4;
      err_d   = ERR_NONE;
    end else begin
      phase_c = phase_q;
      fcnt_d  = fcnt_q;
      dlen_d  = dlen_q;
      lacc_d  = lacc_q;
      prem_d  = prem_q;
      udp_d   = udp_q;
      akind_d = akind_q;
      err_d   = err_q;
    end
    phase_d = phase_c;
    kind    = KIND_CMD;
    idx     = '0;
    last    = 1'b0;
    flen    = '0;

    frame = (phase_c == PH_U_ATYP) || (phase_c == PH_U_DLEN) ||
            (phase_c == PH_U_ADDR) || (phase_c == PH_U_PORT);
    case (akind_d)
      ADDR_IPV4: abytes = IPV4_BYTES;
      ADDR_IPV6: abytes = IPV6_BYTES;
      default:   abytes = dlen_d;
    endcase
    fcnt_inc  = fcnt_d + 8'd1;
    lacc_full = {lacc_d[15:8], data_byte_i};
    prem_dec  = prem_d - 16'd1;

    if (err_d == ERR_NONE) begin
      case (phase_c)
        PH_H_ATYP, PH_U_ATYP: begin
          kind   = KIND_ATYP;
          fcnt_d = '0;
          if (data_byte_i == ATYP_IPV4) begin
            akind_d = ADDR_IPV4;
            phase_d = frame ? PH_U_ADDR : PH_H_ADDR;
          end else if (data_byte_i == ATYP_DOMAIN) begin
            akind_d = ADDR_DOMAIN;
            phase_d = frame ? PH_U_DLEN : PH_H_DLEN;
          end else if (data_byte_i == ATYP_IPV6) begin
            akind_d = ADDR_IPV6;
            phase_d = frame ? PH_U_ADDR : PH_H_ADDR;
          end else begin
            akind_d = ADDR_IPV4;
            err_d   = ERR_ATYP;
          end
        end
        PH_H_DLEN, PH_U_DLEN: begin
          kind   = KIND_DLEN;
          dlen_d = data_byte_i;
          fcnt_d = '0;
          // empty domain goes straight to the port
          if (data_byte_i == 8'd0) phase_d = frame ? PH_U_PORT : PH_H_PORT;
          else                     phase_d = frame ? PH_U_ADDR : PH_H_ADDR;
        end
        PH_H_ADDR, PH_U_ADDR: begin
          kind = KIND_ADDR;
          idx  = fcnt_d;
          if (fcnt_inc >= abytes) begin
            fcnt_d  = '0;
            phase_d = frame ? PH_U_PORT : PH_H_PORT;
          end else begin
            fcnt_d = fcnt_inc;
          end
        end
        PH_H_PORT, PH_U_PORT: begin
          kind = KIND_PORT;
          idx  = fcnt_d;
          if (fcnt_d != 8'd0) begin
            fcnt_d  = '0;
            phase_d = frame ? PH_U_LEN : PH_H_CRLF;
          end else begin
            fcnt_d = 8'd1;
          end
        end
        PH_H_CRLF: begin
          kind = KIND_CRLF;
          idx  = fcnt_d;
          if (fcnt_d != 8'd0) begin
            fcnt_d  = '0;
            last    = 1'b1;
            phase_d = udp_d ? PH_U_ATYP : PH_TCP;
          end else begin
            fcnt_d = 8'd1;
          end
        end
        PH_TCP: begin
          kind = KIND_PAYLOAD;
          idx  = fcnt_d;
          if (fcnt_d != IDX_SAT) fcnt_d = fcnt_inc;
        end
        PH_U_LEN: begin
          kind = KIND_LEN;
          idx  = fcnt_d;
          if (fcnt_d == 8'd0) begin
            lacc_d = {data_byte_i, 8'd0};
            fcnt_d = 8'd1;
          end else begin
            lacc_d = lacc_full;
            flen   = lacc_full;
            fcnt_d = '0;
            if (lacc_full > max_udp_payload_i) err_d = ERR_LENGTH;
            else                               phase_d = PH_U_CRLF;
          end
        end
        PH_U_CRLF: begin
          kind = KIND_CRLF;
          idx  = fcnt_d;
          flen = lacc_d;
          if (fcnt_d != 8'd0) begin
            fcnt_d = '0;
            prem_d = lacc_d;
            if (lacc_d == 16'd0) begin
              last    = 1'b1;
              phase_d = PH_U_ATYP;
            end else begin
              phase_d = PH_U_PAY;
            end
          end else begin
            fcnt_d = 8'd1;
          end
        end
        PH_U_PAY: begin
          kind   = KIND_PAYLOAD;
          idx    = fcnt_d;
          flen   = lacc_d;
          prem_d = prem_dec;
          if (prem_dec == 16'd0) begin
            last    = 1'b1;
            fcnt_d  = '0;
            phase_d = PH_U_ATYP;
          end else if (fcnt_d != IDX_SAT) begin
            fcnt_d = fcnt_inc;
          end
        end
        default: begin
          kind   = KIND_CMD;
          fcnt_d = '0;
          if (data_byte_i == CMD_CONNECT) begin
            udp_d   = 1'b0;
            phase_d = PH_H_ATYP;
          end else if (data_byte_i == CMD_UDP_ASSOC) begin
            udp_d   = 1'b1;
            phase_d = PH_H_ATYP;
          end else begin
            phase_d = PH_CMD;
            err_d   = ERR_CMD;
          end
        end
      endcase
    end

    result_o.data_out     = data_byte_i;
    result_o.byte_kind    = kind;
    result_o.is_udp       = udp_d;
    result_o.address_kind = akind_d;
    result_o.field_index  = idx;
    result_o.frame_last   = last;
    result_o.frame_length = flen;
    result_o.error        = (err_d != ERR_NONE);
    result_o.error_code   = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      fcnt_q  <= '0;
      dlen_q  <= '0;
      lacc_q  <= '0;
      prem_q  <= '0;
      udp_q   <= 1'b0;
      akind_q <= ADDR_IPV4;
      err_q   <= ERR_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
      dlen_q  <= dlen_d;
      lacc_q  <= lacc_d;
      prem_q  <= prem_d;
      udp_q   <= udp_d;
      akind_q <= akind_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: src/udpdf_out_reg.sv
module udpdf_out_reg import udpdf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  result_t result_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;
  logic    load;

  // take a new request whenever the held result leaves this cycle or none is held
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    if (load) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
    else valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
